FILE: rtl/srt_pkg.sv
// Shared types and codes for the sorted score rank table.
// Beat structs for both channels and the sequencer state encoding.
// No dependencies.
`default_nettype none

package srt_pkg;

  localparam int SCORE_W   = 32;
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SCORE_W-1:0]  new_score;
    logic [POS_W-1:0]           position;
  } in_beat_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0]  latest_score;
    logic [CNT_OUT_W-1:0]       latest_rank;
    logic signed [SCORE_W-1:0]  score_at_position;
    logic                       position_valid;
    logic [CNT_OUT_W-1:0]       entry_count;
    logic                       insert_refused;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_POS,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

FILE: rtl/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_score_rank_table.sv
// Sorted score rank table: top level with sequencer and datapath.
// Depends on srt_pkg (types, state codes) and srt_ram (score storage).
`default_nettype none

// Keeps up to TABLE_DEPTH signed 32-bit scores in descending order in a
// single RAM, plus the entry count and the latest inserted score. Every input
// beat (insert or query) returns one output beat describing the state after
// it: latest score and its one-based rank (1 + number of stored scores
// strictly greater), the score at the requested position with a valid flag,
// the entry count and a refused flag for an insert into a full table.
// Sequence: an accepted query or refused insert goes from ST_IDLE to ST_POS
// and ST_DONE; an insert first runs the scan in ST_SCAN, then ST_PLACE when
// the new score lands at the top, and goes straight to ST_PLACE into an
// empty table. ST_DONE loads the output beat once the output register is
// free; a held output beat stretches the item. The insert cost is set by
// the insertion scan, which walks the table from the bottom entry upward
// through the one RAM read port, one entry per cycle, moving each smaller
// entry down one slot and counting strictly greater ones for the rank.
// in_ready is high only while the sequencer is idle; a finished beat sits in
// the output register, so the next item is accepted while it waits. No
// clearing pass: only entries below the count are ever used.

module sorted_score_rank_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire srt_pkg::in_beat_t in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      srt_pkg::out_beat_t out_data
);

  import srt_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  // sequencer
  seq_state_t state, state_next;

  // captured item
  logic                      item_insert;
  logic signed [SCORE_W-1:0] item_score;
  logic [POS_W-1:0]          item_pos;
  logic                      item_refused;

  // scan control
  logic [ADDR_W-1:0] idx;
  logic              placed;
  logic [CNT_W-1:0]  gt_cnt;

  // architectural state
  logic [CNT_W-1:0]          held_count;
  logic signed [SCORE_W-1:0] last_added;
  logic [CNT_W-1:0]          latest_rank;

  // RAM port
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic signed [SCORE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr;
  logic signed [SCORE_W-1:0] ram_rdata;

  // control strobes
  logic accept;
  logic insert_done;
  logic load_out;

  // shared comparator pair on the scanned entry
  logic new_gt_entry;
  logic entry_gt_new;
  logic scan_hit;
  logic full;
  logic pos_ok;
  logic [EXT_W-1:0] count_ext;
  logic [EXT_W-1:0] rank_ext;

  srt_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign new_gt_entry = item_score > ram_rdata;
  assign entry_gt_new = ram_rdata > item_score;
  assign scan_hit     = (state == ST_SCAN) && entry_gt_new;
  assign full         = held_count >= CNT_W'(TABLE_DEPTH);
  assign count_ext    = EXT_W'(held_count);
  assign rank_ext     = EXT_W'(latest_rank);
  assign pos_ok       = EXT_W'(item_pos) < count_ext;
  assign accept       = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_INSERT && !full) begin
            state_next = (held_count == '0) ? ST_PLACE : ST_SCAN;
          end else begin
            state_next = ST_POS;
          end
        end
      end
      ST_SCAN: begin
        // top reached with new score still above the top entry: ST_PLACE
        // writes it at slot 0
        if (idx == '0) begin
          state_next = (!placed && new_gt_entry) ? ST_PLACE : ST_POS;
        end
      end
      ST_PLACE: state_next = ST_POS;
      ST_POS:   state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx + 1'b1;
    ram_wdata   = item_score;
    ram_raddr   = ADDR_W'(item_pos);
    insert_done = 1'b0;
    load_out    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = ADDR_W'(held_count - 1'b1);
      end
      ST_SCAN: begin
        ram_raddr   = idx - 1'b1;
        ram_we      = !placed;
        ram_wdata   = new_gt_entry ? ram_rdata : item_score;
        insert_done = (idx == '0) && !(!placed && new_gt_entry);
      end
      ST_PLACE: begin
        ram_we      = 1'b1;
        ram_waddr   = '0;
        insert_done = 1'b1;
      end
      ST_POS: begin
      end
      ST_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      held_count  <= '0;
      last_added  <= '0;
      latest_rank <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (insert_done) begin
        held_count  <= held_count + 1'b1;
        last_added  <= item_score;
        latest_rank <= gt_cnt + CNT_W'(scan_hit) + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      item_insert  <= in_data.action == ACT_INSERT;
      item_score   <= in_data.new_score;
      item_pos     <= in_data.position;
      item_refused <= (in_data.action == ACT_INSERT) && full;
      idx          <= ADDR_W'(held_count - 1'b1);
      placed       <= 1'b0;
      gt_cnt       <= '0;
    end else if (state == ST_SCAN) begin
      idx <= idx - 1'b1;
      if (!placed && !new_gt_entry) begin
        placed <= 1'b1;
      end
      if (entry_gt_new) begin
        gt_cnt <= gt_cnt + 1'b1;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.latest_score      <= last_added;
      out_data.latest_rank       <= rank_ext[CNT_OUT_W-1:0];
      out_data.score_at_position <= pos_ok ? ram_rdata : '0;
      out_data.position_valid    <= pos_ok;
      out_data.entry_count       <= count_ext[CNT_OUT_W-1:0];
      out_data.insert_refused    <= item_refused && item_insert;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for sorted_score_rank_table: randomized beats on both channels.
// A predictor mirrors the descending table; every output beat is checked field by field.
// Depends on srt_pkg (beat structs, action codes) and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
  import srt_pkg::*;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 5000;  // cycles with no beat on either side
  localparam int RAND_ITEMS = 1100;
  localparam int RX_HOLD    = 400;   // long receiver hold-off, in cycles

  // Pending stimulus: a beat plus a flag that makes the sender wait until
  // every outstanding result has come back before offering it.
  typedef struct {
    in_beat_t beat;
    bit       drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  stim_t     pending[$];
  out_beat_t expected_beats[$];

  // Predictor state: our own copy of the sorted table.
  logic signed [SCORE_W-1:0] tbl_scores[DEPTH];
  int                        tbl_count = 0;
  logic signed [SCORE_W-1:0] tbl_latest = '0;

  int err_count    = 0;
  int n_inserted   = 0;
  int n_refused    = 0;
  int n_queries    = 0;
  int n_results    = 0;
  int idle_cycles  = 0;

  // Sender and receiver pacing counters.
  int  tx_idle_left  = 0;
  int  tx_calm_left  = 0;
  int  rx_stall_left = 0;
  int  rx_calm_left  = 0;
  bit  rx_hold_done  = 1'b0;

  sorted_score_rank_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly back-to-back or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 80);
  endfunction

  // Advance the table model by one beat and return the result it yields.
  // Inserts land after every stored score >= the new one; a full table
  // drops the insert and only raises the refused flag.
  function automatic out_beat_t rank_table_step(in_beat_t b);
    out_beat_t r;
    int        slot;
    int        j;
    int        greater;
    r = '0;
    if (b.action == ACT_INSERT) begin
      if (tbl_count >= DEPTH) begin
        r.insert_refused = 1'b1;
      end else begin
        slot = 0;
        while (slot < tbl_count && !($signed(b.new_score) > $signed(tbl_scores[slot])))
          slot++;
        for (j = tbl_count; j > slot; j--)
          tbl_scores[j] = tbl_scores[j-1];
        tbl_scores[slot] = b.new_score;
        tbl_count++;
        tbl_latest = b.new_score;
      end
    end
    // rank = 1 + number of entries strictly above the latest score
    if (tbl_count > 0) begin
      greater = 0;
      for (j = 0; j < tbl_count; j++)
        if ($signed(tbl_scores[j]) > $signed(tbl_latest)) greater++;
      r.latest_rank = CNT_OUT_W'(greater + 1);
    end
    r.latest_score = tbl_latest;
    if (int'(b.position) < tbl_count) begin
      r.position_valid    = 1'b1;
      r.score_at_position = tbl_scores[b.position];
    end
    r.entry_count = CNT_OUT_W'(tbl_count);
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [SCORE_W-1:0] got, logic [SCORE_W-1:0] want);
    $display("[%0t] MISMATCH beat %0d %s: got %0h want %0h", $time, n_results, what, got, want);
    err_count++;
  endtask

  // Driver: offer the next pending beat when the channel is free, after any gap or drain wait.
  // The prediction is made on the accepting edge, so the expected-result
  // queue always follows accept order.
  always @(posedge clk) begin : drive_proc
    logic      taken;
    out_beat_t pred;
    if (rst) begin
      in_valid     <= 1'b0;
      tx_idle_left <= 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        pred = rank_table_step(in_data);
        expected_beats.push_back(pred);
        if (in_data.action == ACT_QUERY) n_queries++;
        else if (pred.insert_refused) n_refused++;
        else n_inserted++;
      end
      // valid holds until taken; only a free channel picks up new work
      if (!in_valid || taken) begin
        if (tx_idle_left > 0) begin
          tx_idle_left <= tx_idle_left - 1;
          in_valid     <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && expected_beats.size() != 0)) begin
          in_data  <= pending[0].beat;
          in_valid <= 1'b1;
          pending.pop_front();
          // occasional runs of back-to-back beats
          if (tx_calm_left > 0) begin
            tx_calm_left <= tx_calm_left - 1;
            tx_idle_left <= 0;
          end else begin
            if ($urandom_range(0, 49) == 0) tx_calm_left <= 40;
            tx_idle_left <= pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted output beat against the oldest prediction
  // and pace out_ready with random stalls plus one long hold-off.
  always @(posedge clk) begin : mon_proc
    out_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("unexpected beat", out_data.latest_score, '0);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.latest_score !== want.latest_score)
            flag_mismatch("latest_score", out_data.latest_score, want.latest_score);
          if (out_data.latest_rank !== want.latest_rank)
            flag_mismatch("latest_rank", 32'(out_data.latest_rank), 32'(want.latest_rank));
          if (out_data.score_at_position !== want.score_at_position)
            flag_mismatch("score_at_position", out_data.score_at_position,
                          want.score_at_position);
          if (out_data.position_valid !== want.position_valid)
            flag_mismatch("position_valid", 32'(out_data.position_valid),
                          32'(want.position_valid));
          if (out_data.entry_count !== want.entry_count)
            flag_mismatch("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
          if (out_data.insert_refused !== want.insert_refused)
            flag_mismatch("insert_refused", 32'(out_data.insert_refused),
                          32'(want.insert_refused));
        end
        n_results++;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_ready     <= 1'b0;
      end else if (!rx_hold_done && n_results >= 200) begin
        // long hold-off: the sender keeps offering, so the block backs up
        rx_hold_done  <= 1'b1;
        rx_stall_left <= RX_HOLD;
        out_ready     <= 1'b0;
      end else if (rx_calm_left > 0) begin
        rx_calm_left <= rx_calm_left - 1;
        out_ready    <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        rx_stall_left <= pick_gap();
        out_ready     <= 1'b0;
      end else begin
        if ($urandom_range(0, 59) == 0) rx_calm_left <= 80;
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a stretch with no beat on either channel means a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("sorted_score_rank_table regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_item(logic act, logic [SCORE_W-1:0] score, logic [POS_W-1:0] pos,
                          bit drain);
    stim_t s;
    s.beat.action    = act;
    s.beat.new_score = score;
    s.beat.position  = pos;
    s.drain          = drain;
    pending.push_back(s);
  endtask

  initial begin : stim_proc
    logic [SCORE_W-1:0] used_scores[$];
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   pos;
    logic               act;
    int                 gen_count;
    int                 r;
    int                 i;

    // Directed: empty-table queries, extremes, ties at top, middle and
    // bottom, out-of-range positions and alternating bit patterns.
    add_item(ACT_QUERY,  32'd0,          6'd0,  1'b0);  // empty table
    add_item(ACT_QUERY,  32'hFFFF_FFFF,  6'd63, 1'b0);
    add_item(ACT_INSERT, 32'd0,          6'd0,  1'b0);
    add_item(ACT_INSERT, 32'h7FFF_FFFF,  6'd0,  1'b0);  // max lands on top
    add_item(ACT_INSERT, 32'h8000_0000,  6'd2,  1'b0);  // min at bottom
    add_item(ACT_INSERT, 32'h8000_0000,  6'd3,  1'b0);  // tie at bottom
    add_item(ACT_INSERT, 32'd0,          6'd1,  1'b0);  // tie in middle
    add_item(ACT_INSERT, 32'hFFFF_FFFF,  6'd3,  1'b0);  // -1
    add_item(ACT_INSERT, 32'd1,          6'd1,  1'b0);
    add_item(ACT_INSERT, 32'h7FFF_FFFF,  6'd0,  1'b0);  // tie at top
    add_item(ACT_QUERY,  32'd0,          6'd7,  1'b0);  // last valid slot
    add_item(ACT_QUERY,  32'd0,          6'd8,  1'b0);  // first invalid slot
    add_item(ACT_QUERY,  32'h1234_5678,  6'd63, 1'b0);
    add_item(ACT_INSERT, 32'h5555_5555,  6'h2A, 1'b0);
    add_item(ACT_INSERT, 32'hAAAA_AAAA,  6'h15, 1'b0);
    add_item(ACT_QUERY,  32'hAAAA_AAAA,  6'd9,  1'b0);
    add_item(ACT_QUERY,  32'h5555_5555,  6'd10, 1'b0);
    add_item(ACT_QUERY,  32'd0,          6'd4,  1'b1);  // sender drains first
    gen_count = 10;
    used_scores = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1};

    // Random: fill the table with queries in between, then keep pushing
    // refused inserts and queries against the full table.
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (gen_count < DEPTH + 6) act = ($urandom_range(0, 5) == 0) ? ACT_INSERT : ACT_QUERY;
      else act = $urandom_range(0, 1) ? ACT_INSERT : ACT_QUERY;
      r = $urandom_range(0, 99);
      if (r < 30) score = $urandom;
      else if (r < 50) score = 32'($signed($urandom_range(0, 16)) - 8);
      else if (r < 60) begin
        case ($urandom_range(0, 4))
          0: score = 32'h7FFF_FFFF;
          1: score = 32'h8000_0000;
          2: score = 32'd0;
          3: score = 32'hFFFF_FFFF;
          default: score = 32'd1;
        endcase
      end else score = used_scores[$urandom_range(0, used_scores.size() - 1)];
      // mostly positions up to the fill level, some anywhere
      if ($urandom_range(0, 9) < 7)
        pos = POS_W'($urandom_range(0, (gen_count > 63) ? 63 : gen_count));
      else
        pos = POS_W'($urandom);
      if (act == ACT_INSERT) begin
        gen_count++;
        used_scores.push_back(score);
      end
      add_item(act, score, pos, (i == 550) || (i == 900));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // all beats offered and taken, then all results back, then settle
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d inserts stored, %0d refused on a full table, %0d queries",
             n_inserted, n_refused, n_queries);
    $display("checked %0d result beats, %0d mismatches", n_results, err_count);
    if (err_count == 0 && expected_beats.size() == 0) begin
      $display("sorted_score_rank_table regression: pass");
    end else begin
      $display("sorted_score_rank_table regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/srt_pkg.sv
rtl/srt_ram.sv
rtl/sorted_score_rank_table.sv
dv/tb_top.sv
